// ===== design/lbr_pkg.sv =====
// Shared constants, opcodes and item types of the LSB-first bit reader.
package lbr_pkg;

   // Buffer and read sizes.
   localparam int BUFFER_BYTES  = 256;
   localparam int MAX_READ_BITS = 64;

   // Field widths fixed by the interface.
   localparam int OPCODE_W  = 2;
   localparam int BYTE_W    = 8;
   localparam int COUNT_W   = 7;
   localparam int MAX_W     = 32;
   localparam int CAP_W     = 12;
   localparam int VALUE_W   = 64;
   localparam int OUT_POS_W = 12;

   // Derived widths of the buffer bookkeeping.
   localparam int ADDR_W = $clog2(BUFFER_BYTES);
   localparam int LOAD_W = $clog2(BUFFER_BYTES + 1);
   localparam int POS_W  = LOAD_W + 3;
   localparam int RD_W   = (POS_W > CAP_W) ? POS_W : CAP_W;
   localparam int SUM_W  = RD_W + 1;
   localparam int STEP_W = $clog2(MAX_W + 1);

   // Depth of the two small queues; must be a power of two.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Reset value of the length cap.
   localparam logic [CAP_W-1:0] CAP_RESET = 12'd2048;

   // Opcodes.
   localparam logic [OPCODE_W-1:0] OP_APPEND  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_READ    = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_BOUNDED = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_START   = 2'd3;

   // One accepted item, bit count already saturated.
   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [BYTE_W-1:0]   data_byte;
      logic [COUNT_W-1:0]  bit_count;
      logic [MAX_W-1:0]    max_value;
      logic [CAP_W-1:0]    limit_bits;
   } item_type;

   // One result item.
   typedef struct packed {
      logic [VALUE_W-1:0]   value;
      logic                 overflow;
      logic [OUT_POS_W-1:0] bit_position;
      logic [OUT_POS_W-1:0] bits_left;
      logic                 append_dropped;
   } result_type;

endpackage

// ===== design/lbr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module lbr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== design/lbr_front.sv =====
// Front end: accepts request beats, classifies them and queues them for the back end.
module lbr_front import lbr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  logic [BYTE_W-1:0]   req_data_byte,
   input  logic [COUNT_W-1:0]  req_bit_count,
   input  logic [MAX_W-1:0]    req_max_value,
   input  logic [CAP_W-1:0]    req_limit_bits,
   output logic                item_valid,
   output item_type            item,
   input  logic                item_take
);

   item_type            slot_ff [QUEUE_DEPTH];
   item_type            classified;
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push_ok;
   logic                pop_ok;

   // Saturate the bit count so the back end never sees more than a full read.
   always_comb begin
      classified.opcode     = req_opcode;
      classified.data_byte  = req_data_byte;
      classified.max_value  = req_max_value;
      classified.limit_bits = req_limit_bits;
      if (req_bit_count > COUNT_W'(MAX_READ_BITS)) begin
         classified.bit_count = COUNT_W'(MAX_READ_BITS);
      end else begin
         classified.bit_count = req_bit_count;
      end
   end

   assign req_full   = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign item_valid = (count_ff != '0);
   assign item       = slot_ff[rd_ptr_ff];
   assign push_ok    = req_push && !req_full;
   assign pop_ok     = item_take && item_valid;

   // Queue pointers and fill count.
   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

// ===== design/lbr_back.sv =====
// Back end: owns the packet buffer and the read position and carries out each item.
module lbr_back import lbr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       item_valid,
   input  item_type   item,
   output logic       item_take,
   output logic       res_push,
   output result_type res,
   input  logic       res_full
);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_READ    = 2'd1;
   localparam logic [1:0] ST_BOUNDED = 2'd2;
   localparam logic [1:0] ST_DONE    = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [LOAD_W-1:0]  loaded_ff, loaded_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [CAP_W-1:0]   cap_ff, cap_in;
   logic               ovf_ff, ovf_in;
   logic               dropped_ff, dropped_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [COUNT_W-1:0] got_ff, got_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [MAX_W-1:0]   max_ff, max_in;

   logic [POS_W-1:0]   have_bits;
   logic [RD_W-1:0]    readable;
   logic [RD_W-1:0]    left;
   logic               wr_en;
   logic [BYTE_W-1:0]  rd_data;
   logic [2:0]         bit_off;
   logic [3:0]         avail;
   logic [3:0]         take;
   logic [BYTE_W-1:0]  chunk_mask;
   logic [BYTE_W-1:0]  chunk;
   logic [MAX_W-1:0]   trial;
   logic               keep_going;

   // Readable length is the smaller of the cap and the loaded bits.
   assign have_bits = {loaded_ff, 3'b000};
   assign readable  = (RD_W'(cap_ff) < RD_W'(have_bits)) ? RD_W'(cap_ff) : RD_W'(have_bits);
   assign left      = (readable > RD_W'(pos_ff)) ? readable - RD_W'(pos_ff) : '0;

   assign item_take = item_valid && (state_ff == ST_IDLE);
   assign wr_en     = item_take && (item.opcode == OP_APPEND) &&
                      (loaded_ff < LOAD_W'(BUFFER_BYTES));

   // The read address always follows the next position, so the registered rd_data
   // holds the byte under the current position.
   lbr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BUFFER_BYTES)
   ) u_buffer (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (loaded_ff[ADDR_W-1:0]),
      .wr_data (item.data_byte),
      .rd_addr (ADDR_W'(pos_in >> 3)),
      .rd_data (rd_data)
   );

   // Chunk of the current byte that a plain read takes this cycle.
   always_comb begin
      bit_off    = pos_ff[2:0];
      avail      = 4'd8 - {1'b0, bit_off};
      take       = (rem_ff < COUNT_W'(avail)) ? rem_ff[3:0] : avail;
      chunk_mask = BYTE_W'((9'd1 << take) - 9'd1);
      chunk      = (rd_data >> bit_off) & chunk_mask;
   end

   // Bounded-int step test: value plus the next mask must stay below the bound.
   always_comb begin
      trial      = acc_ff[MAX_W-1:0] | (MAX_W'(1) << step_ff[STEP_W-2:0]);
      keep_going = (step_ff != STEP_W'(MAX_W)) && (trial < max_ff);
   end

   // Sequencer.
   always_comb begin
      state_in   = state_ff;
      loaded_in  = loaded_ff;
      pos_in     = pos_ff;
      cap_in     = cap_ff;
      ovf_in     = ovf_ff;
      dropped_in = dropped_ff;
      acc_in     = acc_ff;
      rem_in     = rem_ff;
      got_in     = got_ff;
      step_in    = step_ff;
      max_in     = max_ff;
      res_push   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               acc_in     = '0;
               got_in     = '0;
               step_in    = '0;
               rem_in     = item.bit_count;
               max_in     = item.max_value;
               dropped_in = 1'b0;
               state_in   = ST_DONE;
               case (item.opcode)
                  OP_APPEND: begin
                     if (loaded_ff < LOAD_W'(BUFFER_BYTES)) begin
                        loaded_in = loaded_ff + 1'b1;
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
                  OP_READ: begin
                     if (!ovf_ff) begin
                        if (SUM_W'(pos_ff) + SUM_W'(item.bit_count) > SUM_W'(readable)) begin
                           ovf_in = 1'b1;
                        end else if (item.bit_count != '0) begin
                           state_in = ST_READ;
                        end
                     end
                  end
                  OP_BOUNDED: begin
                     state_in = ST_BOUNDED;
                  end
                  OP_START: begin
                     loaded_in = '0;
                     pos_in    = '0;
                     ovf_in    = 1'b0;
                     cap_in    = item.limit_bits;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_READ: begin
            acc_in = acc_ff | (VALUE_W'(chunk) << got_ff);
            pos_in = pos_ff + POS_W'(take);
            rem_in = rem_ff - COUNT_W'(take);
            got_in = got_ff + COUNT_W'(take);
            if (rem_ff == COUNT_W'(take)) begin
               state_in = ST_DONE;
            end
         end
         ST_BOUNDED: begin
            if (!keep_going) begin
               state_in = ST_DONE;
            end else if (ovf_ff || (RD_W'(pos_ff) >= readable)) begin
               ovf_in   = 1'b1;
               state_in = ST_DONE;
            end else begin
               if (rd_data[bit_off]) begin
                  acc_in = {acc_ff[VALUE_W-1:MAX_W], trial};
               end
               pos_in  = pos_ff + 1'b1;
               step_in = step_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (!res_full) begin
               res_push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result assembled from the settled state.
   always_comb begin
      res.value          = acc_ff;
      res.overflow       = ovf_ff;
      res.bit_position   = OUT_POS_W'(pos_ff);
      res.bits_left      = OUT_POS_W'(left);
      res.append_dropped = dropped_ff;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         loaded_ff <= '0;
         pos_ff    <= '0;
         cap_ff    <= CAP_RESET;
         ovf_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         loaded_ff <= loaded_in;
         pos_ff    <= pos_in;
         cap_ff    <= cap_in;
         ovf_ff    <= ovf_in;
      end
   end

   // Working registers of the current item.
   always_ff @(posedge clock) begin
      dropped_ff <= dropped_in;
      acc_ff     <= acc_in;
      rem_ff     <= rem_in;
      got_ff     <= got_in;
      step_ff    <= step_in;
      max_ff     <= max_in;
   end

   // The position never runs past the readable length.
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      RD_W'(pos_ff) <= readable)
      else $error("read position beyond readable length");

   // The buffer fill never exceeds its capacity.
   a_loaded_in_range: assert property (@(posedge clock) disable iff (reset)
      loaded_ff <= LOAD_W'(BUFFER_BYTES))
      else $error("loaded byte count beyond buffer size");

   // A plain read in progress always has bits left to fetch.
   a_read_has_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (rem_ff != '0))
      else $error("plain read running with nothing left");

   // Every plain-read cycle advances the position.
   a_read_progress: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (pos_ff != $past(pos_ff)))
      else $error("plain read cycle did not advance");

endmodule

// ===== design/lbr_resp.sv =====
// Result queue: holds finished results until the response side pops them.
module lbr_resp import lbr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 res_push,
   input  result_type           res,
   output logic                 res_full,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [VALUE_W-1:0]   rsp_value,
   output logic                 rsp_overflow,
   output logic [OUT_POS_W-1:0] rsp_bit_position,
   output logic [OUT_POS_W-1:0] rsp_bits_left,
   output logic                 rsp_append_dropped
);

   result_type          slot_ff [QUEUE_DEPTH];
   result_type          head;
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push_ok;
   logic                pop_ok;

   assign res_full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign rsp_empty = (count_ff == '0);
   assign push_ok   = res_push && !res_full;
   assign pop_ok    = rsp_pop && !rsp_empty;
   assign head      = slot_ff[rd_ptr_ff];

   // Oldest result on the ports.
   assign rsp_value          = head.value;
   assign rsp_overflow       = head.overflow;
   assign rsp_bit_position   = head.bit_position;
   assign rsp_bits_left      = head.bits_left;
   assign rsp_append_dropped = head.append_dropped;

   // Queue pointers and fill count.
   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= res;
      end
   end

endmodule

// ===== design/lsb_first_bit_reader.sv =====
// Top level of the LSB-first bit reader with bounded-int reads.
//
//   Channel   Handshake          Beat contents
//   req_      push / full        opcode, data_byte, bit_count, max_value, limit_bits
//   rsp_      empty / pop        value, overflow, bit_position, bits_left, append_dropped
//
// Append and start-packet items go from idle straight to done in the back end; a
// plain read takes the bits of one buffer byte per step; a bounded-int read reads one
// bit per step, and its last step only tests the stop. Reset is synchronous; the
// buffer contents are not cleared and are never read before being written. Two-entry
// queues on both sides absorb stalls.
module lsb_first_bit_reader import lbr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [OPCODE_W-1:0]  req_opcode,
   input  logic [BYTE_W-1:0]    req_data_byte,
   input  logic [COUNT_W-1:0]   req_bit_count,
   input  logic [MAX_W-1:0]     req_max_value,
   input  logic [CAP_W-1:0]     req_limit_bits,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [VALUE_W-1:0]   rsp_value,
   output logic                 rsp_overflow,
   output logic [OUT_POS_W-1:0] rsp_bit_position,
   output logic [OUT_POS_W-1:0] rsp_bits_left,
   output logic                 rsp_append_dropped
);

   logic       item_valid;
   item_type   item;
   logic       item_take;
   logic       res_push;
   result_type res;
   logic       res_full;

   lbr_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_opcode     (req_opcode),
      .req_data_byte  (req_data_byte),
      .req_bit_count  (req_bit_count),
      .req_max_value  (req_max_value),
      .req_limit_bits (req_limit_bits),
      .item_valid     (item_valid),
      .item           (item),
      .item_take      (item_take)
   );

   lbr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .res_push   (res_push),
      .res        (res),
      .res_full   (res_full)
   );

   lbr_resp u_resp (
      .clock              (clock),
      .reset              (reset),
      .res_push           (res_push),
      .res                (res),
      .res_full           (res_full),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_value          (rsp_value),
      .rsp_overflow       (rsp_overflow),
      .rsp_bit_position   (rsp_bit_position),
      .rsp_bits_left      (rsp_bits_left),
      .rsp_append_dropped (rsp_append_dropped)
   );

endmodule

// ===== tb/sv/lsb_first_bit_reader_checker.sv =====
// Checker for the LSB-first bit reader: shadow model, expected-result queue and comparison.
`timescale 1ns / 1ps

module lsb_first_bit_reader_checker import lbr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  logic                 req_full,
   input  logic [OPCODE_W-1:0]  req_opcode,
   input  logic [BYTE_W-1:0]    req_data_byte,
   input  logic [COUNT_W-1:0]   req_bit_count,
   input  logic [MAX_W-1:0]     req_max_value,
   input  logic [CAP_W-1:0]     req_limit_bits,
   input  logic                 rsp_empty,
   input  logic                 rsp_pop,
   input  logic [VALUE_W-1:0]   rsp_value,
   input  logic                 rsp_overflow,
   input  logic [OUT_POS_W-1:0] rsp_bit_position,
   input  logic [OUT_POS_W-1:0] rsp_bits_left,
   input  logic                 rsp_append_dropped,
   output int                   failures,
   output int                   pending_results
);

   // Shadow copy of the packet buffer and read bookkeeping.
   logic [BYTE_W-1:0] shadow_bytes [BUFFER_BYTES];
   int unsigned       shadow_loaded;
   int unsigned       shadow_pos;
   int unsigned       shadow_cap;
   bit                shadow_ovf;
   result_type        shadow_rsp_q [$];
   int                fail_tally = 0;

   // Readable length is the smaller of the cap and the loaded bits.
   function automatic int unsigned readable_limit();
      int unsigned have;
      have = shadow_loaded * 8;
      return (shadow_cap < have) ? shadow_cap : have;
   endfunction

   // Checks that n more bits fit; a miss sets the sticky overflow flag.
   function automatic bit claim_bits(int unsigned n);
      if (shadow_ovf)
         return 1'b0;
      if (shadow_pos + n > readable_limit()) begin
         shadow_ovf = 1'b1;
         return 1'b0;
      end
      return 1'b1;
   endfunction

   // Takes the next bit, LSB first within each byte.
   function automatic bit take_bit();
      int unsigned idx;
      bit          b;
      idx = shadow_pos >> 3;
      b = 1'b0;
      if (idx < BUFFER_BYTES)
         b = shadow_bytes[idx][shadow_pos & 7];
      shadow_pos++;
      return b;
   endfunction

   // Adds one expected result at the tail of the queue.
   function automatic void queue_expected(result_type r);
      shadow_rsp_q.insert(shadow_rsp_q.size(), r);
   endfunction

   // Applies one accepted beat to the shadow state and returns its result.
   function automatic result_type step_shadow_reader(item_type beat);
      result_type  r;
      int unsigned n;
      int unsigned rd;
      int unsigned i;
      logic [32:0] mask;
      logic [32:0] acc;
      bit          stopped;
      r = '0;
      case (beat.opcode)
         OP_APPEND: begin
            if (shadow_loaded < BUFFER_BYTES) begin
               shadow_bytes[shadow_loaded] = beat.data_byte;
               shadow_loaded++;
            end else begin
               r.append_dropped = 1'b1;
            end
         end
         OP_READ: begin
            // Counts above the widest read saturate.
            n = (beat.bit_count > MAX_READ_BITS) ? MAX_READ_BITS : beat.bit_count;
            if (claim_bits(n)) begin
               for (i = 0; i < n; i++)
                  r.value[i] = take_bit();
            end
         end
         OP_BOUNDED: begin
            // One bit per mask while value plus mask stays below the bound;
            // an overflow part way keeps the bits already read.
            if (beat.max_value != '0) begin
               acc = '0;
               stopped = 1'b0;
               for (mask = 33'd1; !stopped && mask < 33'h1_0000_0000 &&
                    acc + mask < {1'b0, beat.max_value}; mask = mask << 1) begin
                  if (!claim_bits(1))
                     stopped = 1'b1;
                  else if (take_bit())
                     acc = acc | mask;
               end
               r.value = VALUE_W'(acc);
            end
         end
         OP_START: begin
            shadow_loaded = 0;
            shadow_pos = 0;
            shadow_ovf = 1'b0;
            shadow_cap = beat.limit_bits;
         end
         default: begin
         end
      endcase
      rd = readable_limit();
      r.overflow = shadow_ovf;
      r.bit_position = OUT_POS_W'(shadow_pos);
      r.bits_left = OUT_POS_W'((rd > shadow_pos) ? rd - shadow_pos : 0);
      return r;
   endfunction

   // Compare each popped beat with the oldest expectation, then predict new input beats.
   always @(posedge clock) begin
      item_type   beat;
      result_type want;
      if (reset) begin
         shadow_loaded = 0;
         shadow_pos = 0;
         shadow_cap = CAP_RESET;
         shadow_ovf = 1'b0;
         shadow_rsp_q.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (shadow_rsp_q.size() == 0) begin
               $error("unexpected result beat: value %h", rsp_value);
               fail_tally++;
            end else begin
               want = shadow_rsp_q.pop_front();
               if (rsp_value !== want.value) begin
                  $error("value: expected %h, actual %h", want.value, rsp_value);
                  fail_tally++;
               end
               if (rsp_overflow !== want.overflow) begin
                  $error("overflow: expected %b, actual %b", want.overflow, rsp_overflow);
                  fail_tally++;
               end
               if (rsp_bit_position !== want.bit_position) begin
                  $error("bit_position: expected %0d, actual %0d",
                         want.bit_position, rsp_bit_position);
                  fail_tally++;
               end
               if (rsp_bits_left !== want.bits_left) begin
                  $error("bits_left: expected %0d, actual %0d", want.bits_left, rsp_bits_left);
                  fail_tally++;
               end
               if (rsp_append_dropped !== want.append_dropped) begin
                  $error("append_dropped: expected %b, actual %b",
                         want.append_dropped, rsp_append_dropped);
                  fail_tally++;
               end
            end
         end
         if (req_push && !req_full) begin
            beat.opcode = req_opcode;
            beat.data_byte = req_data_byte;
            beat.bit_count = req_bit_count;
            beat.max_value = req_max_value;
            beat.limit_bits = req_limit_bits;
            queue_expected(step_shadow_reader(beat));
         end
      end
      failures <= fail_tally;
      pending_results <= shadow_rsp_q.size();
   end

endmodule

// ===== tb/sv/lsb_first_bit_reader_tb.sv =====
// Testbench top for the LSB-first bit reader: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps

module lsb_first_bit_reader_tb;
   import lbr_pkg::*;

   localparam int ITEM_TARGET    = 1850;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 60;

   typedef enum int {DRAIN_FULL, DRAIN_HALF, DRAIN_SPARSE} drain_mode_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_push = 1'b0;
   logic                 req_full;
   logic [OPCODE_W-1:0]  req_opcode = OP_APPEND;
   logic [BYTE_W-1:0]    req_data_byte = '0;
   logic [COUNT_W-1:0]   req_bit_count = '0;
   logic [MAX_W-1:0]     req_max_value = '0;
   logic [CAP_W-1:0]     req_limit_bits = '0;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   logic [VALUE_W-1:0]   rsp_value;
   logic                 rsp_overflow;
   logic [OUT_POS_W-1:0] rsp_bit_position;
   logic [OUT_POS_W-1:0] rsp_bits_left;
   logic                 rsp_append_dropped;

   int             failures;
   int             pending_results;
   int             items_sent = 0;
   int             burst_left = 0;
   int             idle_cycles = 0;
   bit             hold_request = 1'b0;
   bit             hold_done = 1'b0;
   int             hold_left = 0;
   int             mode_left = 0;
   drain_mode_type drain_mode = DRAIN_FULL;

   lsb_first_bit_reader dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_opcode         (req_opcode),
      .req_data_byte      (req_data_byte),
      .req_bit_count      (req_bit_count),
      .req_max_value      (req_max_value),
      .req_limit_bits     (req_limit_bits),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_value          (rsp_value),
      .rsp_overflow       (rsp_overflow),
      .rsp_bit_position   (rsp_bit_position),
      .rsp_bits_left      (rsp_bits_left),
      .rsp_append_dropped (rsp_append_dropped)
   );

   lsb_first_bit_reader_checker checker_inst (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_opcode         (req_opcode),
      .req_data_byte      (req_data_byte),
      .req_bit_count      (req_bit_count),
      .req_max_value      (req_max_value),
      .req_limit_bits     (req_limit_bits),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_value          (rsp_value),
      .rsp_overflow       (rsp_overflow),
      .rsp_bit_position   (rsp_bit_position),
      .rsp_bits_left      (rsp_bits_left),
      .rsp_append_dropped (rsp_append_dropped),
      .failures           (failures),
      .pending_results    (pending_results)
   );

   always #2 clock = ~clock;

   function automatic item_type make_item(logic [OPCODE_W-1:0] op, logic [BYTE_W-1:0] b,
                                          logic [COUNT_W-1:0] c, logic [MAX_W-1:0] m,
                                          logic [CAP_W-1:0] l);
      item_type beat;
      beat.opcode = op;
      beat.data_byte = b;
      beat.bit_count = c;
      beat.max_value = m;
      beat.limit_bits = l;
      return beat;
   endfunction

   // Offers one beat, inserting a random gap between bursts, and waits until it is taken.
   task automatic send_item(item_type beat);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 30);
         if (gap > 0) begin
            @(negedge clock);
            req_push <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_push <= 1'b1;
      req_opcode <= beat.opcode;
      req_data_byte <= beat.data_byte;
      req_bit_count <= beat.bit_count;
      req_max_value <= beat.max_value;
      req_limit_bits <= beat.limit_bits;
      @(posedge clock);
      while (req_full) @(posedge clock);
      items_sent++;
   endtask

   // Bounds for the bounded-int read: tiny, powers of two and neighbors, 16-bit, full range.
   function automatic logic [MAX_W-1:0] pick_bound();
      logic [MAX_W-1:0] m;
      case ($urandom_range(0, 4))
         0: m = MAX_W'($urandom_range(0, 40));
         1: m = (MAX_W'(1) << $urandom_range(0, 31)) + MAX_W'($urandom_range(0, 2)) - 1;
         2: m = $urandom;
         3: m = '1;
         default: m = MAX_W'($urandom_range(0, 65535));
      endcase
      return m;
   endfunction

   // Receiver: one long hold-off on request, otherwise a changing pop pattern.
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
      end else if (hold_request && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_pop <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            case ($urandom_range(0, 3))
               0, 1: drain_mode = DRAIN_FULL;
               2: drain_mode = DRAIN_HALF;
               default: drain_mode = DRAIN_SPARSE;
            endcase
            mode_left = $urandom_range(8, 100);
         end
         mode_left--;
         case (drain_mode)
            DRAIN_FULL: rsp_pop <= 1'b1;
            DRAIN_HALF: rsp_pop <= 1'($urandom_range(0, 1));
            default: rsp_pop <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Watchdog: ends the run when no beat moves on either side for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL lsb_first_bit_reader");
            $finish;
         end
      end
   end

   // Stimulus: directed cases, then random packets, then drain and verdict.
   initial begin
      int          pkt_len;
      int          n_ops;
      int          sel;
      int          cnt;
      int          packets;
      logic [CAP_W-1:0] lim;
      logic [BYTE_W-1:0] pattern [9];

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // A read with nothing loaded overflows at once.
      send_item(make_item(OP_READ, 8'h00, 7'd8, '0, '0));
      // Cap far above the loaded length; the loaded length rules.
      send_item(make_item(OP_START, 8'h00, 7'd0, '0, 12'hFFF));
      pattern = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h3C, 8'hC3, 8'h81, 8'h7E, 8'h01};
      foreach (pattern[k])
         send_item(make_item(OP_APPEND, pattern[k], 7'd0, '0, '0));
      // Zero-bit read, widest read, zero and one bounds.
      send_item(make_item(OP_READ, 8'h00, 7'd0, '0, '0));
      send_item(make_item(OP_READ, 8'h00, 7'd64, '0, '0));
      send_item(make_item(OP_BOUNDED, 8'h00, 7'd0, 32'd0, '0));
      send_item(make_item(OP_BOUNDED, 8'h00, 7'd0, 32'd1, '0));
      // Count beyond the widest read saturates and overflows; later reads give zero.
      send_item(make_item(OP_READ, 8'h00, 7'd127, '0, '0));
      send_item(make_item(OP_READ, 8'h00, 7'd0, '0, '0));
      send_item(make_item(OP_BOUNDED, 8'h00, 7'd0, 32'hFFFF_FFFF, '0));
      // Bounded read overflowing part way keeps the bits read so far.
      send_item(make_item(OP_START, 8'h00, 7'd0, '0, 12'd20));
      repeat (3) send_item(make_item(OP_APPEND, 8'hFF, 7'd0, '0, '0));
      send_item(make_item(OP_BOUNDED, 8'h00, 7'd0, 32'hFFFF_FFFF, '0));
      // A zero cap makes every nonempty read overflow.
      send_item(make_item(OP_START, 8'h00, 7'd0, '0, 12'd0));
      send_item(make_item(OP_APPEND, 8'h80, 7'd0, '0, '0));
      send_item(make_item(OP_READ, 8'h00, 7'd1, '0, '0));

      // Random packets: start, load, then a run of reads with some noise mixed in.
      packets = 0;
      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= 600)
            hold_request = 1'b1;
         if (packets == 0 || $urandom_range(0, 59) == 0)
            pkt_len = $urandom_range(BUFFER_BYTES, BUFFER_BYTES + 4);
         else if ($urandom_range(0, 3) == 0)
            pkt_len = $urandom_range(9, 40);
         else
            pkt_len = $urandom_range(0, 12);
         case ($urandom_range(0, 5))
            0: lim = CAP_W'($urandom_range(0, 4095));
            1: lim = CAP_RESET;
            2: lim = CAP_W'(pkt_len * 8);
            3: lim = CAP_W'($urandom_range(0, pkt_len * 8));
            default: lim = CAP_W'(pkt_len * 8 + $urandom_range(0, 64));
         endcase
         send_item(make_item(OP_START, BYTE_W'($urandom), COUNT_W'($urandom),
                             $urandom, lim));
         repeat (pkt_len)
            send_item(make_item(OP_APPEND, BYTE_W'($urandom), COUNT_W'($urandom),
                                $urandom, CAP_W'($urandom)));
         n_ops = $urandom_range(2, 14);
         repeat (n_ops) begin
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4, 5: cnt = $urandom_range(0, 16);
                  6, 7: cnt = $urandom_range(17, 64);
                  8: cnt = MAX_READ_BITS;
                  default: cnt = $urandom_range(65, 127);
               endcase
               send_item(make_item(OP_READ, BYTE_W'($urandom), COUNT_W'(cnt),
                                   $urandom, CAP_W'($urandom)));
            end else if (sel < 80) begin
               send_item(make_item(OP_BOUNDED, BYTE_W'($urandom), COUNT_W'($urandom),
                                   pick_bound(), CAP_W'($urandom)));
            end else if (sel < 92) begin
               send_item(make_item(OP_APPEND, BYTE_W'($urandom), COUNT_W'($urandom),
                                   $urandom, CAP_W'($urandom)));
            end else if (sel < 96) begin
               send_item(make_item(OP_START, BYTE_W'($urandom), COUNT_W'($urandom),
                                   $urandom, CAP_W'($urandom)));
            end else begin
               send_item(make_item(OPCODE_W'($urandom), BYTE_W'($urandom),
                                   COUNT_W'($urandom), $urandom, CAP_W'($urandom)));
            end
         end
         packets++;
      end

      @(negedge clock);
      req_push <= 1'b0;
      while (pending_results != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && pending_results == 0)
         $display("PASS lsb_first_bit_reader");
      else
         $display("FAIL lsb_first_bit_reader");
      $finish;
   end

endmodule
